[sv/frsl_pkg.sv]
// ----------------------------------------------------------------------------
// frsl_pkg
// Shared types and codes for the flash record slot log: the input and result
// words, the mode and result kind codes, and the controller command group.
// ----------------------------------------------------------------------------
package frsl_pkg;

    // input modes
    localparam logic [1:0] MODE_STAGE   = 2'd0;
    localparam logic [1:0] MODE_COMMIT  = 2'd1;
    localparam logic [1:0] MODE_LOAD    = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SAVE_DONE = 2'd0;
    localparam logic [1:0] KIND_LOAD_WORD = 2'd1;
    localparam logic [1:0] KIND_NO_RECORD = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  word_index;
        logic [15:0] word_value;
    } t_in;

    // result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot_number;
        logic        page_erased;
        logic [2:0]  out_index;
        logic [15:0] out_value;
        logic        last;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic       stage_we;
        logic       clr_valid;
        logic       set_valid;
        logic       mem_we;
        logic       mem_re;
        logic       load_we;
        logic       emit;
        logic [1:0] kind;
        logic       erased;
        logic       last;
    } t_cmd;

endpackage

[sv/frsl_ctrl.sv]
// ----------------------------------------------------------------------------
// frsl_ctrl
// Sequencer for the slot log: scans slot marks one slot a cycle, then walks
// the record words of the chosen slot through the page memory.
// ----------------------------------------------------------------------------
module frsl_ctrl #(
    parameter int RECORD_WORDS = 8,
    parameter int SLOT_COUNT   = 32,
    parameter int SW           = 5,
    parameter int WW           = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [1:0]           i_mode,
    input  logic                 i_slot_valid,
    output logic                 busy,
    output logic [SW-1:0]        o_slot,
    output logic [WW-1:0]        o_word,
    output frsl_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN_C = 3'd1;
    localparam logic [2:0] S_PROG   = 3'd2;
    localparam logic [2:0] S_SCAN_L = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_RDW    = 3'd5;

    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam logic [WW-1:0] LAST_WORD = WW'(RECORD_WORDS - 1);

    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_slot, n_slot;
    logic [WW-1:0] r_word, n_word;
    logic          r_erased, n_erased;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_word   = r_word;
        n_erased = r_erased;
        o_cmd    = '0;
        o_cmd.erased = r_erased;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_slot   = '0;
                    n_word   = '0;
                    n_erased = 1'b0;
                    unique case (i_mode)
                        frsl_pkg::MODE_STAGE:  o_cmd.stage_we = 1'b1;
                        frsl_pkg::MODE_COMMIT: n_state = S_SCAN_C;
                        frsl_pkg::MODE_LOAD:   n_state = S_SCAN_L;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN_C: begin
                // first unmarked slot is blank; none means erase the page
                if (!i_slot_valid) begin
                    n_state = S_PROG;
                end else if (r_slot == LAST_SLOT) begin
                    o_cmd.clr_valid = 1'b1;
                    n_slot   = '0;
                    n_erased = 1'b1;
                    n_state  = S_PROG;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_PROG: begin
                // one record word per cycle, mark and report on the last
                o_cmd.mem_we = 1'b1;
                if (r_word == LAST_WORD) begin
                    o_cmd.set_valid = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = frsl_pkg::KIND_SAVE_DONE;
                    o_cmd.last      = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_SCAN_L: begin
                // end of the leading run of marked slots
                if (!i_slot_valid) begin
                    if (r_slot == '0) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = frsl_pkg::KIND_NO_RECORD;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_slot  = r_slot - 1'b1;
                        n_state = S_RD;
                    end
                end else if (r_slot == LAST_SLOT) begin
                    n_state = S_RD;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_RD: begin
                o_cmd.mem_re = 1'b1;
                n_state      = S_RDW;
            end
            S_RDW: begin
                // read word is back: copy to the buffer and send it
                o_cmd.load_we = 1'b1;
                o_cmd.emit    = 1'b1;
                o_cmd.kind    = frsl_pkg::KIND_LOAD_WORD;
                o_cmd.last    = (r_word == LAST_WORD);
                if (r_word == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_word   <= '0;
            r_erased <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_word   <= n_word;
            r_erased <= n_erased;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_slot = r_slot;
    assign o_word = r_word;

endmodule

[sv/frsl_dp.sv]
// ----------------------------------------------------------------------------
// frsl_dp
// Datapath for the slot log: record buffer, per-slot mark bits, record word
// memory of the page and the result register.
// ----------------------------------------------------------------------------
module frsl_dp #(
    parameter int RECORD_WORDS = 8,
    parameter int SLOT_COUNT   = 32,
    parameter int SW           = 5,
    parameter int WW           = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frsl_pkg::t_in     i_item,
    input  frsl_pkg::t_cmd    i_cmd,
    input  logic [SW-1:0]     i_slot,
    input  logic [WW-1:0]     i_word,
    output logic              o_slot_valid,
    output logic              o_strobe,
    output frsl_pkg::t_out    o_result
);

    localparam int MEM_DEPTH = 1 << (SW + WW);

    logic [15:0]           r_buf [RECORD_WORDS];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [15:0]           r_mem [MEM_DEPTH];
    logic [15:0]           r_rd_data;
    logic                  r_strobe;
    frsl_pkg::t_out        r_out;
    logic [SW+WW-1:0]      mem_addr;
    logic [WW-1:0]         stage_idx;
    logic                  stage_ok;

    assign mem_addr  = {i_slot, i_word};
    assign stage_idx = WW'(i_item.word_index);
    assign stage_ok  = (32'(i_item.word_index) < RECORD_WORDS);

    // record buffer: staged words or words read back on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RECORD_WORDS; k++) begin
                r_buf[k] <= '0;
            end
        end else if (i_cmd.stage_we && stage_ok) begin
            r_buf[stage_idx] <= i_item.word_value;
        end else if (i_cmd.load_we) begin
            r_buf[i_word] <= r_rd_data;
        end
    end

    // slot marks: an unmarked slot reads as fully erased
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clr_valid) begin
            r_valid <= '0;
        end else if (i_cmd.set_valid) begin
            r_valid[i_slot] <= 1'b1;
        end
    end

    assign o_slot_valid = r_valid[i_slot];

    // record word memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[mem_addr] <= r_buf[i_word];
        end
        if (i_cmd.mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.kind        <= i_cmd.kind;
            r_out.slot_number <= 5'(i_slot);
            r_out.page_erased <= (i_cmd.kind == frsl_pkg::KIND_SAVE_DONE) && i_cmd.erased;
            r_out.last        <= i_cmd.last;
            if (i_cmd.kind == frsl_pkg::KIND_LOAD_WORD) begin
                r_out.out_index <= 3'(i_word);
                r_out.out_value <= r_rd_data;
            end else begin
                r_out.out_index <= '0;
                r_out.out_value <= '0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

[sv/flash_record_slot_log.sv]
// ----------------------------------------------------------------------------
// flash_record_slot_log
// Record log on one page of slots, each a header mark and RECORD_WORDS words.
// ----------------------------------------------------------------------------
// Usage:
//   An input word is taken when start is high and busy is low. Stage words
//   (mode 0) each fill one word of the record buffer and give no result. A commit
//   (mode 1) writes the buffer into the first blank slot, erasing the page
//   and using slot 0 when none is blank. A load (mode 2) streams out the
//   record of the last slot in the leading run of marked slots, or reports
//   that no record exists.
//   Results appear on o_result for one cycle with o_strobe high; the receiver
//   cannot stall, and last marks the final result of each input word.
// Timing:
//   commit: the mark scan checks one slot a cycle until it finds a blank
//   slot or reaches the last one, then the single port word memory takes
//   one record word a cycle.
//   load: the mark scan, then for each word a memory read, then a send.
//   busy drops in the cycle the last result is shown.
// Reset:
//   clears all slot marks (the page reads as erased at once) and the record
//   buffer to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flash_record_slot_log #(
    parameter int RECORD_WORDS = 8,
    parameter int SLOT_COUNT   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  frsl_pkg::t_in   i_item,
    output logic            busy,
    output logic            o_strobe,
    output frsl_pkg::t_out  o_result
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WW = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;

    frsl_pkg::t_cmd cmd;
    logic [SW-1:0]  slot;
    logic [WW-1:0]  word;
    logic           slot_valid;

    // sequencer
    frsl_ctrl #(
        .RECORD_WORDS (RECORD_WORDS),
        .SLOT_COUNT   (SLOT_COUNT),
        .SW           (SW),
        .WW           (WW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_mode       (i_item.mode),
        .i_slot_valid (slot_valid),
        .busy         (busy),
        .o_slot       (slot),
        .o_word       (word),
        .o_cmd        (cmd)
    );

    // storage and result register
    frsl_dp #(
        .RECORD_WORDS (RECORD_WORDS),
        .SLOT_COUNT   (SLOT_COUNT),
        .SW           (SW),
        .WW           (WW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cmd        (cmd),
        .i_slot       (slot),
        .i_word       (word),
        .o_slot_valid (slot_valid),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    // final result of a word leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy)
        else $error("busy still high on final result");

    // earlier results of a load come while the block is still working
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("idle with results still pending");

    // a staged word finishes at once with no result
    a_stage_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.mode == frsl_pkg::MODE_STAGE) |=> !busy && !o_strobe)
        else $error("stage word caused activity");

endmodule
